FILE: hdl/pcbp_pkg.sv
`default_nettype none

package pcbp_pkg;

    // Fixed widths of the transfer fields.
    localparam int REQ_TYPE_BITS = 2;
    localparam int SYMBOL_BITS   = 8;
    localparam int CODE_BITS     = 32;
    localparam int LEN_BITS      = 6;
    localparam int BYTE_BITS     = 8;
    localparam int BUF_BITS      = 7;
    localparam int FILL_BITS     = 3;

    // Request codes. Code 3 is unused and is ignored.
    typedef enum logic [REQ_TYPE_BITS-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_FLUSH  = 2'd2
    } t_req_type;

    // One input transfer.
    typedef struct packed {
        logic [REQ_TYPE_BITS-1:0] req_type;
        logic [SYMBOL_BITS-1:0]   symbol;
        logic [CODE_BITS-1:0]     code_value;
        logic [LEN_BITS-1:0]      code_length;
    } t_req;

    // One output transfer.
    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 last;
    } t_result;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/pcbp_ram.sv
`default_nettype none

module pcbp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/prefix_code_bit_packer_unit.sv
`default_nettype none
// A load writes the table entry. An encode reads the table, passes through the lookup and emit
// states, and gives its bytes from registered outputs, one byte per cycle, with no gap.
// A flush gives its byte on the cycle after the transfer. Loads and flushes can follow every
// cycle while no encode holds busy; an encode holds busy through its lookup and each byte.
// The receiver cannot stall; each byte is shown for one cycle on o_strobe.
// Synchronous active-low reset empties the bit buffer and marks every table entry as no code.
module prefix_code_bit_packer_unit #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire pcbp_pkg::t_req   i_req,
    output logic                  busy,
    output logic                  o_strobe,
    output pcbp_pkg::t_result     o_result
);

    import pcbp_pkg::*;

    localparam int CAP = (MAX_CODE_LEN < CODE_BITS) ? MAX_CODE_LEN : CODE_BITS;
    localparam int LW  = $clog2(CAP + 1);
    localparam int EW  = CAP + LW;
    localparam int AB  = $clog2(SYMBOL_COUNT);
    localparam int AW  = BUF_BITS + CAP;
    localparam int TW  = $clog2(AW + 1);

    // Registers and next values.
    t_state               r_state, n_state;
    logic [BUF_BITS-1:0]  r_buf, n_buf;
    logic [FILL_BITS-1:0] r_fill, n_fill;
    logic [AW-1:0]        r_acc, n_acc;
    logic [TW-1:0]        r_total, n_total;
    logic                 r_strobe, n_strobe;
    t_result              r_result, n_result;
    logic                 r_rd_vld;
    logic                 r_valid [SYMBOL_COUNT];

    // Decoded request.
    logic            acc_req;
    logic            sym_ok;
    logic [AB-1:0]   sym_idx;
    logic            do_load;
    logic            do_encode;
    logic [LW-1:0]   load_len;
    logic [CAP-1:0]  load_mask;
    logic [EW-1:0]   wr_data;
    logic [EW-1:0]   rd_data;

    // Lookup and emit arithmetic.
    logic [LW-1:0]   look_len;
    logic [CAP-1:0]  look_code;
    logic [AW-1:0]   look_acc;
    logic [TW-1:0]   look_total;
    logic [TW-1:0]   emit_rem;
    logic [BUF_BITS-1:0] rem_mask;

    assign acc_req   = start && !busy;
    assign sym_ok    = {1'b0, i_req.symbol} < (SYMBOL_BITS + 1)'(SYMBOL_COUNT);
    assign sym_idx   = i_req.symbol[AB-1:0];
    assign do_load   = acc_req && sym_ok && (i_req.req_type == REQ_LOAD);
    assign do_encode = acc_req && sym_ok && (i_req.req_type == REQ_ENCODE);

    // Saturate the loaded length and keep only its low code bits.
    always_comb begin
        if (i_req.code_length > LEN_BITS'(CAP)) begin
            load_len = LW'(CAP);
        end else begin
            load_len = i_req.code_length[LW-1:0];
        end
        for (int i = 0; i < CAP; i++) begin
            load_mask[i] = (LW'(i) < load_len);
        end
    end

    assign wr_data = {load_len, i_req.code_value[CAP-1:0] & load_mask};

    pcbp_ram #(
        .WIDTH(EW),
        .DEPTH(SYMBOL_COUNT)
    ) u_code_ram (
        .i_clk  (i_clk),
        .i_we   (do_load),
        .i_waddr(sym_idx),
        .i_wdata(wr_data),
        .i_re   (do_encode),
        .i_raddr(sym_idx),
        .o_rdata(rd_data)
    );

    // Entry valid bits: an entry never loaded since reset reads as no code.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SYMBOL_COUNT; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (do_load) begin
            r_valid[sym_idx] <= 1'b1;
        end
    end

    // Valid bit is registered alongside the RAM read, like the data.
    always_ff @(posedge i_clk) begin
        if (do_encode) begin
            r_rd_vld <= r_valid[sym_idx];
        end
    end

    // Append the looked-up code below the pending bits.
    assign look_len   = r_rd_vld ? rd_data[EW-1 -: LW] : '0;
    assign look_code  = r_rd_vld ? rd_data[CAP-1:0] : '0;
    assign look_acc   = (AW'(r_buf) << look_len) | AW'(look_code);
    assign look_total = TW'(r_fill) + TW'(look_len);

    // Bits left after the byte emitted this cycle.
    assign emit_rem = r_total - TW'(BYTE_BITS);
    assign rem_mask = BUF_BITS'((8'd1 << emit_rem[FILL_BITS-1:0]) - 8'd1);

    // Sequencer: next state and outputs.
    always_comb begin
        n_state  = r_state;
        n_buf    = r_buf;
        n_fill   = r_fill;
        n_acc    = r_acc;
        n_total  = r_total;
        n_strobe = 1'b0;
        n_result = r_result;
        unique case (r_state)
            ST_IDLE: begin
                if (do_encode) begin
                    n_state = ST_LOOKUP;
                end else if (acc_req && (i_req.req_type == REQ_FLUSH) && (r_fill != '0)) begin
                    n_strobe          = 1'b1;
                    n_result.out_byte = BYTE_BITS'({1'b0, r_buf} << (4'd8 - {1'b0, r_fill}));
                    n_result.last     = 1'b1;
                    n_buf             = '0;
                    n_fill            = '0;
                end
            end
            ST_LOOKUP: begin
                if (look_len == '0) begin
                    n_state = ST_IDLE;
                end else if (look_total < TW'(BYTE_BITS)) begin
                    n_buf   = look_acc[BUF_BITS-1:0];
                    n_fill  = look_total[FILL_BITS-1:0];
                    n_state = ST_IDLE;
                end else begin
                    n_acc   = look_acc;
                    n_total = look_total;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                n_strobe          = 1'b1;
                n_result.out_byte = BYTE_BITS'(r_acc >> emit_rem);
                n_result.last     = (emit_rem < TW'(BYTE_BITS));
                n_total           = emit_rem;
                if (emit_rem < TW'(BYTE_BITS)) begin
                    n_buf   = r_acc[BUF_BITS-1:0] & rem_mask;
                    n_fill  = emit_rem[FILL_BITS-1:0];
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_buf    <= '0;
            r_fill   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_buf    <= n_buf;
            r_fill   <= n_fill;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_total  <= n_total;
        r_result <= n_result;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef SYNTH
    // The byte loop only runs while a whole byte is pending.
    a_emit_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_total >= TW'(BYTE_BITS)))
        else $error("byte loop entered without a full byte");

    // Bytes of one encode come on consecutive cycles.
    a_bytes_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=> o_strobe)
        else $error("gap inside a byte burst");

    // An accepted encode always starts a table lookup.
    a_encode_looks_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_encode |=> (r_state == ST_LOOKUP))
        else $error("encode did not start a lookup");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

import pcbp_pkg::*;

// Tracks the code table and bit buffer of the packer and keeps the bytes it should emit.
class packer_scoreboard;
    logic [CODE_BITS-1:0] code_bits [256];
    logic [LEN_BITS-1:0]  code_len [256];
    logic [BUF_BITS-1:0]  buf_bits;
    int                   buf_fill;
    t_result              expected_bytes [$];
    int                   error_count;

    function new();
        foreach (code_len[i]) begin
            code_bits[i] = '0;
            code_len[i]  = '0;
        end
        buf_bits    = '0;
        buf_fill    = 0;
        error_count = 0;
    endfunction

    // Updates the model for one accepted transfer and queues the bytes it causes.
    function void note_request(t_req req);
        logic [63:0] acc;
        logic [15:0] padded;
        int          len;
        int          total;
        int          emitted;
        t_result     item;
        case (req.req_type)
            REQ_LOAD: begin
                // Lengths above 32 saturate; bits above the length are dropped.
                len = req.code_length;
                if (len > 32) begin
                    len = 32;
                end
                code_len[req.symbol]  = LEN_BITS'(len);
                code_bits[req.symbol] = CODE_BITS'(64'(req.code_value) & ((64'd1 << len) - 1));
            end
            REQ_ENCODE: begin
                len = code_len[req.symbol];
                if (len != 0) begin
                    acc     = (64'(buf_bits) << len) | 64'(code_bits[req.symbol]);
                    total   = buf_fill + len;
                    emitted = 0;
                    while (total >= 8) begin
                        item.out_byte = acc[total-8 +: 8];
                        item.last     = 1'b0;
                        expected_bytes = {expected_bytes, item};
                        emitted++;
                        total -= 8;
                    end
                    if (emitted > 0) begin
                        expected_bytes[expected_bytes.size()-1].last = 1'b1;
                    end
                    buf_fill = total;
                    buf_bits = BUF_BITS'(acc & ((64'd1 << total) - 1));
                end
            end
            REQ_FLUSH: begin
                // The partial byte leaves with zeros in its low bits.
                if (buf_fill != 0) begin
                    padded        = 16'(buf_bits) << (8 - buf_fill);
                    item.out_byte = padded[7:0];
                    item.last     = 1'b1;
                    expected_bytes = {expected_bytes, item};
                    buf_bits = '0;
                    buf_fill = 0;
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Compares one emitted byte with the oldest one waiting.
    function void check_result(t_result got);
        t_result want;
        if (expected_bytes.size() == 0) begin
            $error("unexpected result: out_byte=%02h last=%0b", got.out_byte, got.last);
            error_count++;
            return;
        end
        want = expected_bytes.pop_front();
        if (got.out_byte !== want.out_byte) begin
            $error("out_byte mismatch: expected %02h, actual %02h", want.out_byte, got.out_byte);
            error_count++;
        end
        if (got.last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, got.last);
            error_count++;
        end
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction
endclass

module tb_top;

    localparam logic [REQ_TYPE_BITS-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 155;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_req    i_req;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    packer_scoreboard sb = new();
    int cycle_count = 0;
    int sent_count;

    prefix_code_bit_packer_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Every strobed byte is checked at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            sb.check_result(o_result);
        end
    end

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic t_req make_req(logic [1:0] kind, logic [7:0] sym,
                                      logic [31:0] value, logic [5:0] len);
        t_req r;
        r.req_type    = kind;
        r.symbol      = sym;
        r.code_value  = value;
        r.code_length = len;
        return r;
    endfunction

    // Holds a request until the packer takes it; called and returning at a falling edge.
    task automatic send_request(t_req r);
        i_req <= r;
        start <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        sb.note_request(r);
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Drops start and waits on falling edges until every expected byte has come.
    task automatic wait_for_drain();
        start <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (sb.pending() != 0);
    endtask

    // Symbols cluster on a small set so that encodes mostly find loaded codes.
    function automatic logic [7:0] pick_symbol(int hot_percent);
        if ($urandom_range(0, 99) < hot_percent) begin
            return 8'($urandom_range(0, 15));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_req random_request();
        int          roll;
        int          len_roll;
        logic [5:0]  len;
        roll     = $urandom_range(0, 99);
        len_roll = $urandom_range(0, 19);
        if (len_roll == 0) begin
            len = 6'd0;
        end else if (len_roll == 1) begin
            len = 6'd32;
        end else if (len_roll == 2) begin
            len = 6'($urandom_range(33, 63));
        end else if (len_roll == 3) begin
            len = 6'($urandom_range(13, 31));
        end else begin
            len = 6'($urandom_range(1, 12));
        end
        if (roll < 20) begin
            return make_req(REQ_LOAD, pick_symbol(60), $urandom, len);
        end else if (roll < 80) begin
            return make_req(REQ_ENCODE, pick_symbol(80), $urandom, len);
        end else if (roll < 94) begin
            return make_req(REQ_FLUSH, 8'($urandom), $urandom, 6'($urandom));
        end
        return make_req(REQ_UNUSED, 8'($urandom), $urandom, 6'($urandom));
    endfunction

    initial begin
        int burst;
        int gap;
        bit paused_mid;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req      = '0;
        sent_count = 0;
        paused_mid = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: empty table, saturation, masking, flushes and the unused code.
        send_request(make_req(REQ_ENCODE, 8'd0, 32'h0, 6'd0));
        send_request(make_req(REQ_FLUSH, 8'd0, 32'h0, 6'd0));
        send_request(make_req(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63));
        send_request(make_req(REQ_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd0));
        send_request(make_req(REQ_ENCODE, 8'd0, 32'h0, 6'd0));
        send_request(make_req(REQ_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32));
        send_request(make_req(REQ_ENCODE, 8'd255, 32'h0, 6'd0));
        send_request(make_req(REQ_LOAD, 8'd1, 32'hFFFF_FFF5, 6'd3));
        send_request(make_req(REQ_ENCODE, 8'd1, 32'h0, 6'd0));
        send_request(make_req(REQ_ENCODE, 8'd255, 32'h0, 6'd0));
        send_request(make_req(REQ_LOAD, 8'd2, 32'h0, 6'd63));
        send_request(make_req(REQ_ENCODE, 8'd2, 32'h0, 6'd0));
        send_request(make_req(REQ_LOAD, 8'd3, 32'hAAAA_AAAA, 6'd33));
        send_request(make_req(REQ_ENCODE, 8'd3, 32'h0, 6'd0));
        send_request(make_req(REQ_FLUSH, 8'd0, 32'h0, 6'd0));
        send_request(make_req(REQ_LOAD, 8'd4, 32'h1, 6'd1));
        send_request(make_req(REQ_LOAD, 8'd5, 32'h7F, 6'd7));
        send_request(make_req(REQ_ENCODE, 8'd4, 32'h0, 6'd0));
        send_request(make_req(REQ_ENCODE, 8'd5, 32'h0, 6'd0));
        send_request(make_req(REQ_FLUSH, 8'd0, 32'h0, 6'd0));
        send_request(make_req(REQ_LOAD, 8'd6, 32'h1F, 6'd5));
        send_request(make_req(REQ_ENCODE, 8'd6, 32'h0, 6'd0));
        send_request(make_req(REQ_ENCODE, 8'd255, 32'h0, 6'd0));
        send_request(make_req(REQ_FLUSH, 8'd0, 32'h0, 6'd0));
        wait_for_drain();
        idle_cycles(3);

        // Random part in bursts with random gaps; one full drain midway.
        sent_count = 0;
        while (sent_count < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            if (burst > RANDOM_ITEMS - sent_count) begin
                burst = RANDOM_ITEMS - sent_count;
            end
            repeat (burst) begin
                send_request(random_request());
            end
            if (!paused_mid && sent_count >= RANDOM_ITEMS / 2) begin
                paused_mid = 1'b1;
                wait_for_drain();
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            idle_cycles(gap);
        end
        send_request(make_req(REQ_FLUSH, 8'd0, 32'h0, 6'd0));

        // Let the last bytes arrive, then watch for strays.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
